[rtl/wdg_pkg.sv]
// Package for the multi-slot two-stage watchdog.
// Holds the command codes, register indexes, field widths and the controller types.
// Depends on nothing.
`timescale 1ns / 1ps

package wdg_pkg;

   localparam int WDG_SLOTS      = 8;
   localparam int SLOT_W         = 3;
   localparam int TIMER_W        = 16;
   localparam int FLAGS_W        = 8;
   localparam int CSR_IDX_W      = 1;
   localparam int REQ_TDATA_W    = 8;
   localparam int RSP_TDATA_W    = 24;

   localparam logic [TIMER_W-1:0] SOFT_RESET = 16'd30;
   localparam logic [TIMER_W-1:0] HARD_RESET = 16'd20;

   typedef enum logic [1:0] {
      CMD_START     = 2'd0,
      CMD_STOP      = 2'd1,
      CMD_ABORT_ALL = 2'd2,
      CMD_TICK      = 2'd3
   } wdg_cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOFT_TIMEOUT = 1'd0,
      REG_HARD_TIMEOUT = 1'd1
   } wdg_reg_type;

   typedef enum logic {
      CTL_EMPTY,
      CTL_FULL
   } wdg_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic step;   // a request beat is taken: update the slots and the result
   } wdg_ctl_type;

endpackage

[rtl/wdg_ctrl.sv]
// Handshake controller of the watchdog: owns the result-valid state.
// Depends on wdg_pkg.
`timescale 1ns / 1ps

module wdg_ctrl
   import wdg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output wdg_ctl_type ctl
);

   wdg_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new beat may be taken while the held result leaves in the same cycle.
   always_comb begin
      state_in   = state_ff;
      rsp_tvalid = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         CTL_EMPTY: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = CTL_FULL;
            end
         end
         CTL_FULL: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
            if (rsp_tready && !req_tvalid) begin
               state_in = CTL_EMPTY;
            end
         end
         default: begin
            state_in = CTL_EMPTY;
         end
      endcase
      ctl.step = req_tvalid && req_tready;
   end

endmodule

[rtl/wdg_datapath.sv]
// Datapath of the watchdog: timeout registers, per-slot timers and flags, result register.
// Depends on wdg_pkg; driven by wdg_ctrl.
`timescale 1ns / 1ps

module wdg_datapath
   import wdg_pkg::*;
#(
   parameter int SLOTS = WDG_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wdg_ctl_type            ctl,
   input  logic [1:0]             command,
   input  logic [SLOT_W-1:0]      slot,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [TIMER_W-1:0]     csr_wdata,
   output logic [FLAGS_W-1:0]     abort_flags,
   output logic [FLAGS_W-1:0]     recover_mask,
   output logic                   slot_abort
);

   logic [TIMER_W-1:0] soft_cfg_ff, hard_cfg_ff;

   logic [TIMER_W-1:0] soft_rem_ff  [SLOTS];
   logic [TIMER_W-1:0] soft_rem_in  [SLOTS];
   logic [TIMER_W-1:0] hard_rem_ff  [SLOTS];
   logic [TIMER_W-1:0] hard_rem_in  [SLOTS];
   logic [SLOTS-1:0]   soft_arm_ff, soft_arm_in;
   logic [SLOTS-1:0]   hard_arm_ff, hard_arm_in;
   logic [SLOTS-1:0]   flag_ff, flag_in;
   logic [SLOTS-1:0]   recover;
   logic [SLOTS-1:0]   slot_hit;

   logic [FLAGS_W-1:0] flags_ff, flags_in;
   logic [FLAGS_W-1:0] recov_ff, recov_in;
   logic               sabort_ff, sabort_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         soft_cfg_ff <= SOFT_RESET;
         hard_cfg_ff <= HARD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_SOFT_TIMEOUT: soft_cfg_ff <= csr_wdata;
            REG_HARD_TIMEOUT: hard_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic hard_exp;
      logic soft_exp;
      for (int i = 0; i < SLOTS; i++) begin
         slot_hit[i]    = (32'(slot) == i);
         soft_rem_in[i] = soft_rem_ff[i];
         hard_rem_in[i] = hard_rem_ff[i];
         soft_arm_in[i] = soft_arm_ff[i];
         hard_arm_in[i] = hard_arm_ff[i];
         flag_in[i]     = flag_ff[i];
         recover[i]     = 1'b0;
         hard_exp       = hard_arm_ff[i] && (hard_rem_ff[i] <= TIMER_W'(1));
         soft_exp       = soft_arm_ff[i] && (soft_rem_ff[i] <= TIMER_W'(1));
         case (command)
            CMD_START: begin
               if (slot_hit[i]) begin
                  flag_in[i]     = 1'b0;
                  soft_rem_in[i] = soft_cfg_ff;
                  soft_arm_in[i] = 1'b1;
               end
            end
            CMD_STOP: begin
               if (slot_hit[i]) begin
                  soft_arm_in[i] = 1'b0;
                  hard_arm_in[i] = 1'b0;
                  soft_rem_in[i] = '0;
                  hard_rem_in[i] = '0;
                  flag_in[i]     = 1'b0;
               end
            end
            CMD_ABORT_ALL: begin
               flag_in[i] = 1'b1;
            end
            default: begin
               // Hard expiry wins over a soft expiry on the same tick.
               if (hard_exp) begin
                  soft_arm_in[i] = 1'b0;
                  hard_arm_in[i] = 1'b0;
                  soft_rem_in[i] = '0;
                  hard_rem_in[i] = '0;
                  flag_in[i]     = 1'b0;
                  recover[i]     = 1'b1;
               end else if (soft_exp) begin
                  soft_arm_in[i] = 1'b0;
                  soft_rem_in[i] = '0;
                  flag_in[i]     = 1'b1;
                  hard_rem_in[i] = hard_cfg_ff;
                  hard_arm_in[i] = 1'b1;
               end else begin
                  if (soft_arm_ff[i]) soft_rem_in[i] = soft_rem_ff[i] - TIMER_W'(1);
                  if (hard_arm_ff[i]) hard_rem_in[i] = hard_rem_ff[i] - TIMER_W'(1);
               end
            end
         endcase
      end
   end

   // Only the first eight slots show in the result masks.
   always_comb begin
      flags_in  = '0;
      recov_in  = '0;
      sabort_in = |(slot_hit & flag_in);
      for (int b = 0; b < FLAGS_W; b++) begin
         if (b < SLOTS) begin
            flags_in[b] = flag_in[b % SLOTS];
            recov_in[b] = recover[b % SLOTS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         soft_arm_ff <= '0;
         hard_arm_ff <= '0;
         flag_ff     <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            soft_rem_ff[i] <= '0;
            hard_rem_ff[i] <= '0;
         end
      end else if (ctl.step) begin
         soft_arm_ff <= soft_arm_in;
         hard_arm_ff <= hard_arm_in;
         flag_ff     <= flag_in;
         for (int i = 0; i < SLOTS; i++) begin
            soft_rem_ff[i] <= soft_rem_in[i];
            hard_rem_ff[i] <= hard_rem_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         flags_ff  <= flags_in;
         recov_ff  <= recov_in;
         sabort_ff <= sabort_in;
      end
   end

   assign abort_flags  = flags_ff;
   assign recover_mask = recov_ff;
   assign slot_abort   = sabort_ff;

endmodule

[rtl/multi_slot_two_stage_watchdog.sv]
// Top level of the multi-slot two-stage watchdog.
// Depends on wdg_pkg, wdg_ctrl and wdg_datapath.
`timescale 1ns / 1ps

// The block watches SLOTS worker slots, each with a one-shot soft timer, a one-shot
// hard timer and an abort flag. A request beat carries a command in req_tuser (start,
// stop, raise all abort flags, tick) and a slot number in req_tdata. Every beat yields
// exactly one response beat in the following cycle: all per-slot counters are updated
// side by side when the beat is taken, and a single output register holds the response.
// A new request beat is taken in the same cycle as the held response leaves, so with
// rsp_tready high the block sustains one beat per clock. Timeout registers are to be
// written through the csr_ port only while no beat is in flight; the block does not
// check it. A value is sampled whenever a timer is loaded, and a value of zero acts as
// one tick. A slot number at or above SLOTS makes start and stop do nothing and gives
// a slot_abort of zero; slots beyond the eighth never appear in the response masks.

module multi_slot_two_stage_watchdog
   import wdg_pkg::*;
#(
   parameter int SLOTS = WDG_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [2:0] slot, rest zero
   input  logic [1:0]             req_tuser,   // [1:0] command
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] abort_flags, [15:8] recover_mask,
                                               // [16] slot_abort, rest zero
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [TIMER_W-1:0]     csr_wdata
);

   wdg_ctl_type        ctl;
   logic [FLAGS_W-1:0] abort_flags;
   logic [FLAGS_W-1:0] recover_mask;
   logic               slot_abort;

   // The controller alone decides when a beat is taken and when a response is shown.
   wdg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   // The datapath holds the timers, the flags and the registered response.
   wdg_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .command      (req_tuser),
      .slot         (req_tdata[SLOT_W-1:0]),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .abort_flags  (abort_flags),
      .recover_mask (recover_mask),
      .slot_abort   (slot_abort)
   );

   assign rsp_tdata = {7'd0, slot_abort, recover_mask, abort_flags};

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the multi-slot two-stage watchdog.
// Drives command beats, predicts every response beat and compares them field by field.
// Depends on wdg_pkg and multi_slot_two_stage_watchdog.
`timescale 1ns / 1ps

module tb_top;
   import wdg_pkg::*;

   // Long receiver hold-off, in cycles, used once to fill the block and stall its input.
   localparam int LONG_HOLD     = 300;
   // Cycles allowed after the last response so that a stray extra beat is still seen.
   localparam int TAIL_CYCLES   = 10;
   localparam int PHASE_BEATS   = 160;
   localparam int PHASE_COUNT   = 8;

   // One response beat as the checker sees it.
   typedef struct packed {
      logic [FLAGS_W-1:0] abort_flags;
      logic [FLAGS_W-1:0] recover_mask;
      logic               slot_abort;
   } verdict_type;

   // One line of the directed stimulus: either a register write or a command beat,
   // repeated a number of times, optionally with the response typed in by hand.
   typedef struct packed {
      logic                 is_reg;
      wdg_cmd_type          cmd;
      logic [SLOT_W-1:0]    slot;
      wdg_reg_type          reg_idx;
      logic [TIMER_W-1:0]   reg_value;
      int                   repeats;
      logic                 typed;
      verdict_type          verdict;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;    // [2:0] slot, rest zero
   logic [1:0]             req_tuser = CMD_START;   // [1:0] command
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [7:0] abort_flags, [15:8] recover_mask,
                                              // [16] slot_abort, rest zero
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [TIMER_W-1:0]     csr_wdata = '0;

   // A hand-typed response travels beside the request beat it belongs to, driven at the
   // same edge, so that the checker picks it up at exactly that beat's handshake.
   logic                   pinned_valid = 1'b0;
   verdict_type            pinned_verdict = '0;

   // Predicted copy of the block's per-slot state and of its timeout registers.
   logic [TIMER_W-1:0]     soft_left [WDG_SLOTS];
   logic [TIMER_W-1:0]     hard_left [WDG_SLOTS];
   logic                   soft_running [WDG_SLOTS];
   logic                   hard_running [WDG_SLOTS];
   logic                   flag_up [WDG_SLOTS];
   logic [TIMER_W-1:0]     soft_ticks = SOFT_RESET;
   logic [TIMER_W-1:0]     hard_ticks = HARD_RESET;

   verdict_type            awaited_verdicts [$];
   int                     beats_sent = 0;
   int                     results_seen = 0;
   int                     faults = 0;
   int                     sender_idle_pct = 0;
   int                     stall_pct = 0;
   int                     hold_requests = 0;
   int                     holds_served = 0;
   int                     hold_left = 0;

   // Settings of the random phases: timeout registers and how often each side idles.
   int unsigned            soft_plan [PHASE_COUNT] = '{4, 2, 0, 7, 1, 65535, 12, 3};
   int unsigned            hard_plan [PHASE_COUNT] = '{3, 5, 0, 2, 65535, 1, 6, 3};
   int                     idle_plan [PHASE_COUNT] = '{0, 60, 0, 19, 0, 60, 0, 19};
   int                     stall_plan [PHASE_COUNT] = '{0, 0, 60, 19, 0, 0, 60, 19};

   stim_row_type           plan [$];

   multi_slot_two_stage_watchdog dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one accepted command to the predicted slot state and returns the response
   // the block must give for it. On a tick each slot counts its armed timers down first;
   // a hard expiry then wins over a soft expiry of the same tick. A timer loaded with
   // zero expires on the next tick, exactly as one loaded with one.
   function automatic verdict_type apply_command(wdg_cmd_type cmd, logic [SLOT_W-1:0] slot);
      verdict_type v;
      logic        in_range;
      logic        hard_hit;
      logic        soft_hit;
      v = '0;
      in_range = int'(slot) < WDG_SLOTS;
      case (cmd)
         CMD_START: begin
            if (in_range) begin
               flag_up[slot] = 1'b0;
               soft_left[slot] = soft_ticks;
               soft_running[slot] = 1'b1;
            end
         end
         CMD_STOP: begin
            if (in_range) begin
               soft_running[slot] = 1'b0;
               hard_running[slot] = 1'b0;
               soft_left[slot] = '0;
               hard_left[slot] = '0;
               flag_up[slot] = 1'b0;
            end
         end
         CMD_ABORT_ALL: begin
            for (int i = 0; i < WDG_SLOTS; i++)
               flag_up[i] = 1'b1;
         end
         default: begin
            for (int i = 0; i < WDG_SLOTS; i++) begin
               hard_hit = 1'b0;
               soft_hit = 1'b0;
               if (hard_running[i]) begin
                  if (hard_left[i] <= 1) begin
                     hard_left[i] = '0;
                     hard_hit = 1'b1;
                  end else begin
                     hard_left[i] = hard_left[i] - 1'b1;
                  end
               end
               if (soft_running[i]) begin
                  if (soft_left[i] <= 1) begin
                     soft_left[i] = '0;
                     soft_hit = 1'b1;
                  end else begin
                     soft_left[i] = soft_left[i] - 1'b1;
                  end
               end
               if (hard_hit) begin
                  soft_running[i] = 1'b0;
                  hard_running[i] = 1'b0;
                  soft_left[i] = '0;
                  hard_left[i] = '0;
                  flag_up[i] = 1'b0;
                  if (i < FLAGS_W)
                     v.recover_mask[i] = 1'b1;
               end else if (soft_hit) begin
                  soft_running[i] = 1'b0;
                  flag_up[i] = 1'b1;
                  hard_left[i] = hard_ticks;
                  hard_running[i] = 1'b1;
               end
            end
         end
      endcase
      // Slots beyond the eighth never show in the masks.
      for (int i = 0; i < WDG_SLOTS && i < FLAGS_W; i++)
         v.abort_flags[i] = flag_up[i];
      v.slot_abort = in_range && flag_up[in_range ? slot : 0];
      return v;
   endfunction

   function automatic stim_row_type beat_row(wdg_cmd_type cmd, logic [SLOT_W-1:0] slot,
                                             int repeats);
      stim_row_type r;
      r = '0;
      r.cmd = cmd;
      r.slot = slot;
      r.repeats = repeats;
      return r;
   endfunction

   function automatic stim_row_type pinned_row(wdg_cmd_type cmd, logic [SLOT_W-1:0] slot,
                                               logic [7:0] flags, logic [7:0] recover,
                                               logic slot_abort);
      stim_row_type r;
      r = beat_row(cmd, slot, 1);
      r.typed = 1'b1;
      r.verdict.abort_flags = flags;
      r.verdict.recover_mask = recover;
      r.verdict.slot_abort = slot_abort;
      return r;
   endfunction

   function automatic stim_row_type reg_row(wdg_reg_type idx, logic [TIMER_W-1:0] value);
      stim_row_type r;
      r = '0;
      r.is_reg = 1'b1;
      r.reg_idx = idx;
      r.reg_value = value;
      return r;
   endfunction

   // Offers one request beat, after a random number of idle cycles, and returns at the
   // edge where it is taken. Valid stays high afterwards: the caller either offers the
   // next beat or lowers it in that same time step.
   task automatic offer_beat(wdg_cmd_type cmd, logic [SLOT_W-1:0] slot, logic typed,
                             verdict_type verdict);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= REQ_TDATA_W'(slot);
      pinned_valid <= typed;
      pinned_verdict <= verdict;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      beats_sent++;
   endtask

   // Stops offering beats and waits until every beat sent so far has been answered.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (results_seen != beats_sent)
         @(posedge clock);
   endtask

   // Writes one timeout register; only called while the block is idle.
   task automatic write_reg(wdg_reg_type idx, logic [TIMER_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_SOFT_TIMEOUT: soft_ticks = value;
         REG_HARD_TIMEOUT: hard_ticks = value;
         default: ;
      endcase
   endtask

   // Receiver: stalls at the phase's rate, and once holds off for a long stretch so
   // that the block fills up and has to refuse further request beats.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Checker. A response beat at an edge always belongs to a request taken at an
   // earlier edge, so it is compared before this edge's request adds its expectation.
   always @(posedge clock) begin : watch
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.abort_flags = rsp_tdata[7:0];
         got.recover_mask = rsp_tdata[15:8];
         got.slot_abort = rsp_tdata[16];
         results_seen++;
         if (awaited_verdicts.size() == 0) begin
            faults++;
            $display("%0t: response beat %h arrived with none expected", $time, rsp_tdata);
         end else begin
            want = awaited_verdicts.pop_front();
            if (got.abort_flags !== want.abort_flags) begin
               faults++;
               $display("%0t: abort_flags expected %h, actual %h",
                        $time, want.abort_flags, got.abort_flags);
            end
            if (got.recover_mask !== want.recover_mask) begin
               faults++;
               $display("%0t: recover_mask expected %h, actual %h",
                        $time, want.recover_mask, got.recover_mask);
            end
            if (got.slot_abort !== want.slot_abort) begin
               faults++;
               $display("%0t: slot_abort expected %b, actual %b",
                        $time, want.slot_abort, got.slot_abort);
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         want = apply_command(wdg_cmd_type'(req_tuser), req_tdata[SLOT_W-1:0]);
         if (pinned_valid)
            want = pinned_verdict;
         awaited_verdicts.push_back(want);
      end
   end

   // Hard limit on the run, far beyond the slowest correct one.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      wdg_cmd_type cmd;
      int          pick;
      for (int i = 0; i < WDG_SLOTS; i++) begin
         soft_left[i] = '0;
         hard_left[i] = '0;
         soft_running[i] = 1'b0;
         hard_running[i] = 1'b0;
         flag_up[i] = 1'b0;
      end

      // Directed part. The first rows run on the reset timeouts of 30 and 20 ticks: two
      // slots started together expire together, a restart during the hard stage leaves
      // the hard timer running, and its expiry also cancels the restarted soft timer.
      plan.push_back(pinned_row(CMD_TICK, 3'd0, 8'h00, 8'h00, 1'b0));
      plan.push_back(pinned_row(CMD_START, 3'd7, 8'h00, 8'h00, 1'b0));
      plan.push_back(pinned_row(CMD_START, 3'd0, 8'h00, 8'h00, 1'b0));
      plan.push_back(beat_row(CMD_TICK, 3'd4, 29));
      plan.push_back(pinned_row(CMD_TICK, 3'd0, 8'h81, 8'h00, 1'b1));
      plan.push_back(pinned_row(CMD_START, 3'd0, 8'h80, 8'h00, 1'b0));
      plan.push_back(beat_row(CMD_TICK, 3'd2, 19));
      plan.push_back(pinned_row(CMD_TICK, 3'd7, 8'h00, 8'h81, 1'b0));
      // Raising every flag, then stopping slots one by one.
      plan.push_back(pinned_row(CMD_ABORT_ALL, 3'd3, 8'hFF, 8'h00, 1'b1));
      plan.push_back(pinned_row(CMD_STOP, 3'd3, 8'hF7, 8'h00, 1'b0));
      plan.push_back(pinned_row(CMD_STOP, 3'd0, 8'hF6, 8'h00, 1'b0));
      // A zero soft timeout expires on the first tick. Restarting the slot while its
      // one-tick hard timer runs makes both expire on the same tick, and the hard one wins.
      plan.push_back(reg_row(REG_SOFT_TIMEOUT, 16'h0000));
      plan.push_back(reg_row(REG_HARD_TIMEOUT, 16'h0001));
      plan.push_back(pinned_row(CMD_START, 3'd2, 8'hF2, 8'h00, 1'b0));
      plan.push_back(pinned_row(CMD_TICK, 3'd2, 8'hF6, 8'h00, 1'b1));
      plan.push_back(pinned_row(CMD_START, 3'd2, 8'hF2, 8'h00, 1'b0));
      plan.push_back(pinned_row(CMD_TICK, 3'd2, 8'hF2, 8'h04, 1'b0));
      // Largest timeouts.
      plan.push_back(reg_row(REG_SOFT_TIMEOUT, 16'hFFFF));
      plan.push_back(reg_row(REG_HARD_TIMEOUT, 16'hFFFF));
      plan.push_back(pinned_row(CMD_START, 3'd6, 8'hB2, 8'h00, 1'b0));
      plan.push_back(pinned_row(CMD_TICK, 3'd6, 8'hB2, 8'h00, 1'b0));
      plan.push_back(pinned_row(CMD_STOP, 3'd6, 8'hB2, 8'h00, 1'b0));
      plan.push_back(pinned_row(CMD_ABORT_ALL, 3'd5, 8'hFF, 8'h00, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].is_reg) begin
            settle();
            write_reg(plan[r].reg_idx, plan[r].reg_value);
         end else begin
            for (int n = 0; n < plan[r].repeats; n++)
               offer_beat(plan[r].cmd, plan[r].slot, plan[r].typed, plan[r].verdict);
         end
      end

      // Random part: each phase sets new timeouts and its own idling pattern. Ticks
      // dominate so that soft and hard expiries occur often with the short timeouts.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         write_reg(REG_SOFT_TIMEOUT, soft_plan[p][TIMER_W-1:0]);
         write_reg(REG_HARD_TIMEOUT, hard_plan[p][TIMER_W-1:0]);
         sender_idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         for (int k = 0; k < PHASE_BEATS; k++) begin
            // Once the receiver holds off while beats keep coming; once the sender
            // pauses until everything sent has been answered.
            if (p == 0 && k == 40)
               hold_requests++;
            if (p == 3 && k == 85)
               settle();
            pick = $urandom_range(99);
            if (pick < 55)
               cmd = CMD_TICK;
            else if (pick < 85)
               cmd = CMD_START;
            else if (pick < 96)
               cmd = CMD_STOP;
            else
               cmd = CMD_ABORT_ALL;
            offer_beat(cmd, SLOT_W'($urandom_range(WDG_SLOTS - 1)), 1'b0, '0);
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_verdicts.size() != 0) begin
         faults++;
         $display("%0t: %0d expected response beats never arrived",
                  $time, awaited_verdicts.size());
      end
      if (faults == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
